>>> rtl/wall_column_span_projector_defines.svh
// ----------------------------------------------------------------------------
// Wall column span projector assertion macros
// Concurrent assertion helpers shared by the RTL of the projector.
// ----------------------------------------------------------------------------
`ifndef WALL_COLUMN_SPAN_PROJECTOR_DEFINES_SVH
`define WALL_COLUMN_SPAN_PROJECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define WCSP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Antecedent implies consequent in the next cycle.
`define WCSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define WCSP_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define WCSP_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/wcsp_pkg.sv
// ----------------------------------------------------------------------------
// Wall column span projector package
// Shared widths, register indexes, command and status types, sine table.
// ----------------------------------------------------------------------------
package wcsp_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CAMERA_X = 2'd0;
	localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
	localparam logic [1:0] CFG_HEADING  = 2'd2;

	// Input command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Projection constants.
	localparam int FOCAL_LENGTH = 200;
	localparam int CEIL_HEIGHT  = 20;
	localparam int ROW_NUM      = CEIL_HEIGHT * FOCAL_LENGTH;

	// Datapath widths.
	localparam int DIV_W = 36;
	localparam int DSR_W = 21;
	localparam int REL_W = 14;
	localparam int WC_W  = 16;
	localparam int ROW_W = 14;
	localparam int PX_W  = 20;
	localparam int COL_W = 12;

	typedef enum logic [2:0] {
		DIV_CLIP,
		DIV_PX,
		DIV_ROW,
		DIV_QB,
		DIV_QT
	} div_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     ld_in;
		logic     rel;
		logic     rot_mul;
		logic     rot_sum;
		logic     hide;
		logic     clip_mul;
		logic     div_start;
		div_sel_t div_sel;
		logic     fin;
		logic     q_chk;
		logic     q_mul;
		logic     out_load;
		logic     ep;
	} wcsp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic query;
		logic behind0;
		logic behind1;
		logic hit;
		logic div_done;
		logic out_full;
	} wcsp_sts_t;

	// Sine of whole degrees in Q14, first quadrant.
	localparam logic [14:0] SINE_Q14 [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	// Signed Q14 sine of an angle already reduced to 0..359 degrees.
	function automatic logic signed [15:0] sin_q14(input logic [8:0] deg);
		logic [8:0]  idx;
		logic        neg;
		logic signed [15:0] mag;
		if (deg <= 9'd90) begin
			idx = deg;
			neg = 1'b0;
		end else if (deg <= 9'd180) begin
			idx = 9'd180 - deg;
			neg = 1'b0;
		end else if (deg <= 9'd270) begin
			idx = deg - 9'd180;
			neg = 1'b1;
		end else begin
			idx = 9'd360 - deg;
			neg = 1'b1;
		end
		mag = $signed({1'b0, SINE_Q14[idx[6:0]]});
		return neg ? -mag : mag;
	endfunction

endpackage

>>> rtl/wall_column_span_projector.sv
// ----------------------------------------------------------------------------
// Wall column span projector
// Projects one wall segment to screen column spans and answers column queries.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one beat per item: a load
// beat (command 0) takes the wall endpoints and color, a query beat
// (command 1) takes a screen column. Each item gives one result beat on the
// output channel (out_valid / out_stall). Camera position and heading are to
// be written over the configuration channel (cfg_valid / cfg_ready, always
// ready) only while the block is idle; the block does not enforce this.
// Items are worked one at a time; every division goes through one shared
// radix-2 divider. A visible load divides for the column and for the rows
// of each endpoint, with one more division for a near-plane clip; a wall
// wholly behind the camera needs no division. A query inside the drawn
// range divides for the bottom and the top row, and outside it needs none.
// The next item can be taken in the cycle after the result is loaded, even
// while that result still waits in the output register; a stalled receiver
// holds that result and, once the following item is done, the block waits.
// Reset clears the stored wall and restores the default camera.
module wall_column_span_projector #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [11:0] wall_start_x,
	input  logic signed [11:0] wall_start_y,
	input  logic signed [11:0] wall_end_x,
	input  logic signed [11:0] wall_end_y,
	input  logic [7:0]         color_red,
	input  logic [7:0]         color_green,
	input  logic [7:0]         color_blue,
	input  logic [8:0]         column,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible,
	output logic [8:0]         first_column,
	output logic [8:0]         end_column,
	output logic               column_valid,
	output logic [7:0]         span_bottom,
	output logic [7:0]         span_top,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue
);
	import wcsp_pkg::*;

	logic signed [15:0] camera_x_q;
	logic signed [15:0] camera_y_q;
	logic [8:0]         heading_q;

	wcsp_cmd_t cmd;
	wcsp_sts_t sts;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= 16'sd480;
			camera_y_q <= 16'sd320;
			heading_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAMERA_X: camera_x_q <= $signed(cfg_data);
				CFG_CAMERA_Y: camera_y_q <= $signed(cfg_data);
				CFG_HEADING:  heading_q  <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	wcsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	wcsp_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.camera_x     (camera_x_q),
		.camera_y     (camera_y_q),
		.heading      (heading_q),
		.command      (command),
		.wall_start_x (wall_start_x),
		.wall_start_y (wall_start_y),
		.wall_end_x   (wall_end_x),
		.wall_end_y   (wall_end_y),
		.color_red    (color_red),
		.color_green  (color_green),
		.color_blue   (color_blue),
		.column       (column),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.visible      (visible),
		.first_column (first_column),
		.end_column   (end_column),
		.column_valid (column_valid),
		.span_bottom  (span_bottom),
		.span_top     (span_top),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue)
	);

endmodule

>>> rtl/wcsp_div.sv
// ----------------------------------------------------------------------------
// Wall column span projector divider
// Signed radix-2 restoring divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`include "wall_column_span_projector_defines.svh"

module wcsp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [wcsp_pkg::DIV_W-1:0] dividend,
	input  logic signed [wcsp_pkg::DSR_W-1:0] divisor,
	output logic                              done,
	output logic signed [wcsp_pkg::DIV_W-1:0] quotient
);
	import wcsp_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSR_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DSR_W-1:0] dsr_q;
	logic             neg_q;

	logic [DSR_W:0]   shifted;
	logic [DSR_W+1:0] trial;
	logic             ge;

	// One quotient bit per cycle.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign ge      = !trial[DSR_W+1];

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand magnitudes and the partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
			dsr_q <= divisor[DSR_W-1] ? DSR_W'(-divisor) : DSR_W'(divisor);
			rem_q <= '0;
			neg_q <= dividend[DIV_W-1] ^ divisor[DSR_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	`WCSP_ASSERT_IMPL(a_start_idle, clk, arst_n, start, !busy_q)
	`WCSP_ASSERT_NEXT(a_last_done, clk, arst_n, busy_q && (cnt_q == LAST), done_q && !busy_q)
	`WCSP_ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, !busy_q)

endmodule

>>> rtl/wcsp_ctrl.sv
// ----------------------------------------------------------------------------
// Wall column span projector controller
// Sequences the load and query steps of the datapath.
// ----------------------------------------------------------------------------
module wcsp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output wcsp_pkg::wcsp_cmd_t  cmd,
	input  wcsp_pkg::wcsp_sts_t  sts
);
	import wcsp_pkg::*;

	typedef enum logic [14:0] {
		ST_IDLE     = 15'b000000000000001,
		ST_REL      = 15'b000000000000010,
		ST_ROT_MUL  = 15'b000000000000100,
		ST_ROT_SUM  = 15'b000000000001000,
		ST_CHECK    = 15'b000000000010000,
		ST_CLIP_MUL = 15'b000000000100000,
		ST_CLIP_DIV = 15'b000000001000000,
		ST_PX_DIV   = 15'b000000010000000,
		ST_ROW_DIV  = 15'b000000100000000,
		ST_FIN      = 15'b000001000000000,
		ST_Q_CHK    = 15'b000010000000000,
		ST_Q_MUL    = 15'b000100000000000,
		ST_QB_DIV   = 15'b001000000000000,
		ST_QT_DIV   = 15'b010000000000000,
		ST_DONE     = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic   ep_q, ep_d;
	logic   started_q;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		ep_d        = ep_q;
		cmd         = '0;
		cmd.div_sel = DIV_CLIP;
		cmd.ep      = ep_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = sts.query ? ST_Q_CHK : ST_REL;
				end
			end
			ST_REL: begin
				cmd.rel = 1'b1;
				ep_d    = 1'b0;
				state_d = ST_ROT_MUL;
			end
			ST_ROT_MUL: begin
				cmd.rot_mul = 1'b1;
				state_d     = ST_ROT_SUM;
			end
			ST_ROT_SUM: begin
				cmd.rot_sum = 1'b1;
				if (!ep_q) begin
					ep_d    = 1'b1;
					state_d = ST_ROT_MUL;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.behind0 && sts.behind1) begin
					cmd.hide = 1'b1;
					state_d  = ST_DONE;
				end else if (sts.behind0) begin
					ep_d    = 1'b0;
					state_d = ST_CLIP_MUL;
				end else if (sts.behind1) begin
					ep_d    = 1'b1;
					state_d = ST_CLIP_MUL;
				end else begin
					ep_d    = 1'b0;
					state_d = ST_PX_DIV;
				end
			end
			ST_CLIP_MUL: begin
				cmd.clip_mul = 1'b1;
				state_d      = ST_CLIP_DIV;
			end
			ST_CLIP_DIV: begin
				cmd.div_sel   = DIV_CLIP;
				cmd.div_start = !started_q;
				if (sts.div_done) begin
					ep_d    = 1'b0;
					state_d = ST_PX_DIV;
				end
			end
			ST_PX_DIV: begin
				cmd.div_sel   = DIV_PX;
				cmd.div_start = !started_q;
				if (sts.div_done) begin
					state_d = ST_ROW_DIV;
				end
			end
			ST_ROW_DIV: begin
				cmd.div_sel   = DIV_ROW;
				cmd.div_start = !started_q;
				if (sts.div_done) begin
					if (!ep_q) begin
						ep_d    = 1'b1;
						state_d = ST_PX_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_Q_CHK: begin
				cmd.q_chk = 1'b1;
				state_d   = sts.hit ? ST_Q_MUL : ST_DONE;
			end
			ST_Q_MUL: begin
				cmd.q_mul = 1'b1;
				state_d   = ST_QB_DIV;
			end
			ST_QB_DIV: begin
				cmd.div_sel   = DIV_QB;
				cmd.div_start = !started_q;
				if (sts.div_done) begin
					state_d = ST_QT_DIV;
				end
			end
			ST_QT_DIV: begin
				cmd.div_sel   = DIV_QT;
				cmd.div_start = !started_q;
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ep_q      <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ep_q    <= ep_d;
			if (sts.div_done) begin
				started_q <= 1'b0;
			end else if (cmd.div_start) begin
				started_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/wcsp_dp.sv
// ----------------------------------------------------------------------------
// Wall column span projector datapath
// Relative coordinates, rotation, near clip, projection and span lookup.
// ----------------------------------------------------------------------------
module wcsp_dp #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wcsp_pkg::wcsp_cmd_t cmd,
	output wcsp_pkg::wcsp_sts_t sts,
	input  logic signed [15:0]  camera_x,
	input  logic signed [15:0]  camera_y,
	input  logic [8:0]          heading,
	input  logic                command,
	input  logic signed [11:0]  wall_start_x,
	input  logic signed [11:0]  wall_start_y,
	input  logic signed [11:0]  wall_end_x,
	input  logic signed [11:0]  wall_end_y,
	input  logic [7:0]          color_red,
	input  logic [7:0]          color_green,
	input  logic [7:0]          color_blue,
	input  logic [8:0]          column,
	input  logic                out_stall,
	output logic                out_valid,
	output logic                visible,
	output logic [8:0]          first_column,
	output logic [8:0]          end_column,
	output logic                column_valid,
	output logic [7:0]          span_bottom,
	output logic [7:0]          span_top,
	output logic [7:0]          out_red,
	output logic [7:0]          out_green,
	output logic [7:0]          out_blue
);
	import wcsp_pkg::*;

	localparam int HALF_W = SCREEN_WIDTH / 2;
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam logic signed [DIV_W:0]  SAT_MAX = (DIV_W+1)'((1 << (PX_W - 1)) - 1);
	localparam logic signed [DIV_W:0]  SAT_MIN = -(DIV_W+1)'(1 << (PX_W - 1));
	localparam logic signed [DIV_W:0]  H_Q     = (DIV_W+1)'(SCREEN_HEIGHT);
	localparam logic signed [PX_W-1:0] W_PX    = PX_W'(SCREEN_WIDTH);
	localparam logic [COL_W-1:0]       W_COL   = COL_W'(SCREEN_WIDTH);

	// Map point relative to the camera, divided by 16 toward zero.
	function automatic logic signed [REL_W-1:0] rel_coord(
		input logic signed [11:0] m,
		input logic signed [15:0] c
	);
		logic signed [17:0] t;
		logic signed [17:0] adj;
		t   = $signed({{2{m[11]}}, m, 4'b0000}) - 18'(c);
		adj = t + (t[17] ? 18'sd15 : 18'sd0);
		return adj[17:4];
	endfunction

	// Rotated coordinate, divided by 16384 toward zero.
	function automatic logic signed [WC_W-1:0] rot_scale(input logic signed [30:0] v);
		logic signed [30:0] adj;
		adj = v + (v[30] ? 31'sd16383 : 31'sd0);
		return adj[WC_W+13:14];
	endfunction

	// Saturation to the projected column width.
	function automatic logic signed [PX_W-1:0] sat_px(input logic signed [DIV_W:0] v);
		return (v > SAT_MAX) ? PX_W'(SAT_MAX) : ((v < SAT_MIN) ? PX_W'(SAT_MIN) : v[PX_W-1:0]);
	endfunction

	// Row clamp to 0..SCREEN_HEIGHT.
	function automatic logic [COL_W-1:0] clamp_row(input logic signed [DIV_W:0] v);
		return (v < 0) ? '0 : ((v > H_Q) ? COL_W'(H_Q) : v[COL_W-1:0]);
	endfunction

	// Column clamp to 0..SCREEN_WIDTH.
	function automatic logic [COL_W-1:0] clamp_col(input logic signed [PX_W-1:0] v);
		return (v < 0) ? '0 : ((v > W_PX) ? W_COL : v[COL_W-1:0]);
	endfunction

	// Latched input beat.
	logic signed [11:0] sx_q, sy_q, ex_q, ey_q;
	logic [8:0]         col_q;

	// Working values.
	logic signed [REL_W-1:0] rx0_q, ry0_q, rx1_q, ry1_q;
	logic signed [15:0]      cs_q, sn_q;
	logic signed [29:0]      pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic signed [WC_W-1:0]  wx0_q, wy0_q, wx1_q, wy1_q;
	logic signed [32:0]      n1_s1, n2_s1;
	logic signed [16:0]      d_s1;
	logic signed [PX_W-1:0]  px0_q, px1_q;
	logic signed [DIV_W-1:0] prod_b_s1, prod_t_s1;

	// Stored wall.
	logic                   vis_q;
	logic signed [PX_W-1:0] start_q, delta_q;
	logic [COL_W-1:0]       first_q, end_q;
	logic signed [ROW_W-1:0] bot0_q, bot1_q, top0_q, top1_q;
	logic [23:0]            span_color_q;

	// Query result.
	logic             res_valid_q;
	logic [COL_W-1:0] res_bot_q, res_top_q;

	// Output register.
	logic             out_valid_q;

	// Endpoint selection.
	logic signed [REL_W-1:0] rx_e, ry_e;
	logic signed [WC_W-1:0]  wx_e, wy_e, wx_o, wy_o;
	assign rx_e = cmd.ep ? rx1_q : rx0_q;
	assign ry_e = cmd.ep ? ry1_q : ry0_q;
	assign wx_e = cmd.ep ? wx1_q : wx0_q;
	assign wy_e = cmd.ep ? wy1_q : wy0_q;
	assign wx_o = cmd.ep ? wx0_q : wx1_q;
	assign wy_o = cmd.ep ? wy0_q : wy1_q;

	// Heading reduced to 0..359, cosine taken as the sine 90 degrees on.
	logic [8:0] h_mod;
	logic [9:0] c_sum;
	logic [8:0] c_mod;
	assign h_mod = (heading >= 9'd360) ? heading - 9'd360 : heading;
	assign c_sum = 10'(h_mod) + 10'd90;
	assign c_mod = (c_sum >= 10'd360) ? 9'(c_sum - 10'd360) : c_sum[8:0];

	// Near clip operands.
	logic signed [16:0] d_raw, d_fix, dx;
	assign d_raw = 17'(wy_e) - 17'(wy_o);
	assign d_fix = (d_raw == 17'sd0) ? 17'sd1 : d_raw;
	assign dx    = 17'(wx_o) - 17'(wx_e);

	// Query operands.
	logic signed [PX_W:0]  off;
	logic signed [ROW_W:0] db, dt;
	logic signed [DIV_W-1:0] prod_b, prod_t;
	assign off    = $signed((PX_W+1)'(col_q)) - (PX_W+1)'(start_q);
	assign db     = (ROW_W+1)'(bot1_q) - (ROW_W+1)'(bot0_q);
	assign dt     = (ROW_W+1)'(top1_q) - (ROW_W+1)'(top0_q);
	assign prod_b = db * off;
	assign prod_t = dt * off;

	// Divider operand selection.
	logic signed [24:0]      px_num;
	logic signed [DIV_W-1:0] div_n, div_q;
	logic signed [DSR_W-1:0] div_d;
	logic                    div_done;
	assign px_num = 25'(wx_e) * 25'sd200;

	always_comb begin
		case (cmd.div_sel)
			DIV_CLIP: begin
				div_n = DIV_W'(n1_s1) + DIV_W'(n2_s1);
				div_d = DSR_W'(d_s1);
			end
			DIV_PX: begin
				div_n = DIV_W'(px_num);
				div_d = DSR_W'(wy_e);
			end
			DIV_ROW: begin
				div_n = DIV_W'(ROW_NUM);
				div_d = DSR_W'(wy_e);
			end
			DIV_QB: begin
				div_n = prod_b_s1;
				div_d = DSR_W'(delta_q);
			end
			DIV_QT: begin
				div_n = prod_t_s1;
				div_d = DSR_W'(delta_q);
			end
			default: begin
				div_n = '0;
				div_d = DSR_W'(1);
			end
		endcase
	end

	wcsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// Quotient post-processing.
	logic signed [DIV_W:0] q_ext, px_sum, qb_sum, qt_sum;
	logic signed [ROW_W-1:0] q_row;
	logic signed [PX_W:0]  fin_diff;
	logic signed [PX_W-1:0] fin_delta;
	assign q_ext     = (DIV_W+1)'(div_q);
	assign px_sum    = q_ext + (DIV_W+1)'(HALF_W);
	assign qb_sum    = q_ext + (DIV_W+1)'(bot0_q);
	assign qt_sum    = q_ext + (DIV_W+1)'(top0_q);
	assign q_row     = div_q[ROW_W-1:0];
	assign fin_diff  = (PX_W+1)'(px1_q) - (PX_W+1)'(px0_q);
	assign fin_delta = sat_px((DIV_W+1)'(fin_diff));

	logic hit;
	assign hit = vis_q && (COL_W'(col_q) >= first_q) && (COL_W'(col_q) < end_q);

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			sx_q  <= wall_start_x;
			sy_q  <= wall_start_y;
			ex_q  <= wall_end_x;
			ey_q  <= wall_end_y;
			col_q <= column;
		end
		if (cmd.rel) begin
			rx0_q <= rel_coord(sx_q, camera_x);
			ry0_q <= rel_coord(sy_q, camera_y);
			rx1_q <= rel_coord(ex_q, camera_x);
			ry1_q <= rel_coord(ey_q, camera_y);
			cs_q  <= sin_q14(c_mod);
			sn_q  <= sin_q14(h_mod);
		end
		if (cmd.rot_mul) begin
			pxc_s1 <= rx_e * cs_q;
			pys_s1 <= ry_e * sn_q;
			pyc_s1 <= ry_e * cs_q;
			pxs_s1 <= rx_e * sn_q;
		end
		if (cmd.rot_sum) begin
			if (cmd.ep) begin
				wx1_q <= rot_scale(31'(pxc_s1) - 31'(pys_s1));
				wy1_q <= rot_scale(31'(pyc_s1) + 31'(pxs_s1));
			end else begin
				wx0_q <= rot_scale(31'(pxc_s1) - 31'(pys_s1));
				wy0_q <= rot_scale(31'(pyc_s1) + 31'(pxs_s1));
			end
		end
		if (cmd.clip_mul) begin
			n1_s1 <= wx_e * d_fix;
			n2_s1 <= wy_e * dx;
			d_s1  <= d_fix;
		end
		if (div_done && (cmd.div_sel == DIV_CLIP)) begin
			if (cmd.ep) begin
				wx1_q <= div_q[WC_W-1:0];
				wy1_q <= WC_W'(1);
			end else begin
				wx0_q <= div_q[WC_W-1:0];
				wy0_q <= WC_W'(1);
			end
		end
		if (div_done && (cmd.div_sel == DIV_PX)) begin
			if (cmd.ep) begin
				px1_q <= sat_px(px_sum);
			end else begin
				px0_q <= sat_px(px_sum);
			end
		end
		if (cmd.q_mul) begin
			prod_b_s1 <= prod_b;
			prod_t_s1 <= prod_t;
		end
	end

	// Stored wall and query result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q        <= 1'b0;
			start_q      <= '0;
			delta_q      <= PX_W'(1);
			first_q      <= '0;
			end_q        <= '0;
			bot0_q       <= '0;
			bot1_q       <= '0;
			top0_q       <= '0;
			top1_q       <= '0;
			span_color_q <= '0;
			res_valid_q  <= 1'b0;
			res_bot_q    <= '0;
			res_top_q    <= '0;
		end else begin
			if (cmd.ld_in) begin
				res_valid_q <= 1'b0;
				res_bot_q   <= '0;
				res_top_q   <= '0;
				if (command == CMD_LOAD) begin
					span_color_q <= {color_red, color_green, color_blue};
				end
			end
			if (cmd.hide) begin
				vis_q   <= 1'b0;
				start_q <= '0;
				delta_q <= PX_W'(1);
				first_q <= '0;
				end_q   <= '0;
				bot0_q  <= '0;
				bot1_q  <= '0;
				top0_q  <= '0;
				top1_q  <= '0;
			end
			// Floor and ceiling are symmetric, so one quotient serves both rows.
			if (div_done && (cmd.div_sel == DIV_ROW)) begin
				if (cmd.ep) begin
					bot1_q <= ROW_W'(HALF_H) - q_row;
					top1_q <= ROW_W'(HALF_H) + q_row;
				end else begin
					bot0_q <= ROW_W'(HALF_H) - q_row;
					top0_q <= ROW_W'(HALF_H) + q_row;
				end
			end
			if (cmd.fin) begin
				vis_q   <= 1'b1;
				start_q <= px0_q;
				delta_q <= (fin_delta == '0) ? PX_W'(1) : fin_delta;
				first_q <= clamp_col(px0_q);
				end_q   <= clamp_col(px1_q);
			end
			if (cmd.q_chk) begin
				res_valid_q <= hit;
			end
			if (div_done && (cmd.div_sel == DIV_QB)) begin
				res_bot_q <= clamp_row(qb_sum);
			end
			if (div_done && (cmd.div_sel == DIV_QT)) begin
				res_top_q <= clamp_row(qt_sum);
			end
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			visible      <= vis_q;
			first_column <= first_q[8:0];
			end_column   <= end_q[8:0];
			column_valid <= res_valid_q;
			span_bottom  <= res_bot_q[7:0];
			span_top     <= res_top_q[7:0];
			out_red      <= res_valid_q ? span_color_q[23:16] : 8'd0;
			out_green    <= res_valid_q ? span_color_q[15:8] : 8'd0;
			out_blue     <= res_valid_q ? span_color_q[7:0] : 8'd0;
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller.
	always_comb begin
		sts          = '0;
		sts.query    = (command == CMD_QUERY);
		sts.behind0  = wy0_q[WC_W-1] || (wy0_q == '0);
		sts.behind1  = wy1_q[WC_W-1] || (wy1_q == '0);
		sts.hit      = hit;
		sts.div_done = div_done;
		sts.out_full = out_valid_q && out_stall;
	end

endmodule
